// ===== rtl/sha256_pkg.sv =====
package sha256_pkg;

  localparam int COUNT_BITS = 61;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [63:0]           len_t;

  localparam logic [5:0] PAD_LEN_POS = 6'd56;
  localparam logic [7:0] PAD_MARK    = 8'h80;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_OUT
  } state_t;

  // Strobes from the sequencer to the schedule and round units.
  typedef struct packed {
    logic load;
    logic step;
    logic fold;
    logic reinit;
  } ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    round_k = k;
  endfunction

endpackage

// ===== rtl/sha256_sched.sv =====
module sha256_sched (
  input  logic                clk,
  input  sha256_pkg::ctl_t    ctl,
  input  logic [511:0]        blk,
  output logic [31:0]         sched_w
);

  logic [31:0] win [16];
  logic [31:0] w_new;

  // Window holds W[t] .. W[t+15]; the word shifted in is W[t+16].
  assign w_new = sha256_pkg::sml_sig1(win[14]) + win[9]
               + sha256_pkg::sml_sig0(win[1]) + win[0];
  assign sched_w = win[0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 16; i++) begin
        win[i] <= blk[511 - 32*i -: 32];
      end
    end else if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end
  end

endmodule

// ===== rtl/sha256_round.sv =====
module sha256_round (
  input  logic                clk,
  input  logic                rst,
  input  sha256_pkg::ctl_t    ctl,
  input  logic [31:0]         round_k,
  input  logic [31:0]         sched_w,
  input  logic [2:0]          word_sel,
  output logic [31:0]         digest_word
);

  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] t1;
  logic [31:0] t2;

  assign t1 = v[7] + sha256_pkg::big_sig1(v[4]) + sha256_pkg::choose(v[4], v[5], v[6])
            + round_k + sched_w;
  assign t2 = sha256_pkg::big_sig0(v[0]) + sha256_pkg::majority(v[0], v[1], v[2]);

  assign digest_word = chain[word_sel];

  always_ff @(posedge clk) begin
    if (rst || ctl.reinit) begin
      chain <= sha256_pkg::HASH_INIT;
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v <= chain;
    end else if (ctl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

// ===== rtl/sha256_message_digest.sv =====
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  data_byte, byte_present, end_of_message
// digest    out        out_valid / out_stall digest_word, word_index, last_word
//
// A request that does not complete a 64-byte block is taken without stalling.
// A request that fills the block then holds in_stall through the load, the 64
// rounds of the shared round unit and the fold into the chain. End of message
// shifts pad bytes in one per cycle, pausing while a filled block is compressed
// (up to 72 with an extra block), then eight digest words, one per cycle unless
// out_stall holds the current word. Reset is synchronous and loads the initial hash.
module sha256_message_digest (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   data_byte,
  input  logic         byte_present,
  input  logic         end_of_message,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [31:0]  digest_word,
  output logic [2:0]   word_index,
  output logic         last_word
);

  sha256_pkg::state_t state, state_next;
  sha256_pkg::count_t byte_count, count_next;
  sha256_pkg::len_t   len, len_next;
  sha256_pkg::ctl_t   ctl;

  logic [511:0] blk;
  logic [5:0]   fill;
  logic [5:0]   rnd, rnd_next;
  logic [2:0]   idx, idx_next;
  logic         padding, padding_next;
  logic         marked, marked_next;
  logic         extra, extra_next;
  logic         last_blk, last_blk_next;
  logic         byte_wr;
  logic [7:0]   byte_val;
  logic [31:0]  sched_w;

  assign in_stall   = (state != sha256_pkg::S_IDLE);
  assign out_valid  = (state == sha256_pkg::S_OUT);
  assign word_index = idx;
  assign last_word  = (idx == '1);

  always_comb begin
    state_next    = state;
    count_next    = byte_count;
    len_next      = len;
    rnd_next      = rnd;
    idx_next      = idx;
    padding_next  = padding;
    marked_next   = marked;
    extra_next    = extra;
    last_blk_next = last_blk;
    byte_wr       = 1'b0;
    byte_val      = data_byte;
    ctl           = '0;
    case (state)
      sha256_pkg::S_IDLE: begin
        if (in_valid) begin
          if (byte_present) begin
            byte_wr    = 1'b1;
            count_next = sha256_pkg::count_t'(byte_count + 1'b1);
          end
          if (end_of_message) begin
            padding_next  = 1'b1;
            marked_next   = 1'b0;
            extra_next    = 1'b0;
            last_blk_next = 1'b0;
            len_next      = sha256_pkg::len_t'({count_next, 3'b000});
          end
          if (byte_present && fill == '1) begin
            state_next = sha256_pkg::S_LOAD;
          end else if (end_of_message) begin
            state_next = sha256_pkg::S_PAD;
          end
        end
      end
      sha256_pkg::S_LOAD: begin
        ctl.load   = 1'b1;
        rnd_next   = '0;
        state_next = sha256_pkg::S_ROUND;
      end
      sha256_pkg::S_ROUND: begin
        ctl.step = 1'b1;
        rnd_next = rnd + 1'b1;
        if (rnd == '1) begin
          state_next = sha256_pkg::S_FOLD;
        end
      end
      sha256_pkg::S_FOLD: begin
        ctl.fold = 1'b1;
        if (last_blk) begin
          idx_next   = '0;
          state_next = sha256_pkg::S_OUT;
        end else if (padding) begin
          state_next = sha256_pkg::S_PAD;
        end else begin
          state_next = sha256_pkg::S_IDLE;
        end
      end
      sha256_pkg::S_PAD: begin
        byte_wr = 1'b1;
        if (!marked) begin
          byte_val    = sha256_pkg::PAD_MARK;
          marked_next = 1'b1;
          // Mark too late for the length: pad out and use one more block.
          extra_next  = (fill >= sha256_pkg::PAD_LEN_POS);
        end else if (fill >= sha256_pkg::PAD_LEN_POS && !extra) begin
          byte_val = len[63:56];
          len_next = len << 8;
          if (fill == '1) begin
            last_blk_next = 1'b1;
          end
        end else begin
          byte_val = '0;
        end
        if (fill == '1) begin
          extra_next = 1'b0;
          state_next = sha256_pkg::S_LOAD;
        end
      end
      sha256_pkg::S_OUT: begin
        if (!out_stall) begin
          idx_next = idx + 1'b1;
          if (idx == '1) begin
            ctl.reinit    = 1'b1;
            count_next    = '0;
            padding_next  = 1'b0;
            last_blk_next = 1'b0;
            state_next    = sha256_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = sha256_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha256_pkg::S_IDLE;
      byte_count <= '0;
      fill       <= '0;
      rnd        <= '0;
      idx        <= '0;
      padding    <= 1'b0;
      marked     <= 1'b0;
      extra      <= 1'b0;
      last_blk   <= 1'b0;
    end else begin
      state      <= state_next;
      byte_count <= count_next;
      rnd        <= rnd_next;
      idx        <= idx_next;
      padding    <= padding_next;
      marked     <= marked_next;
      extra      <= extra_next;
      last_blk   <= last_blk_next;
      if (byte_wr) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Shift bytes in; after 64 the first byte sits in the top bits.
  always_ff @(posedge clk) begin
    len <= len_next;
    if (byte_wr) begin
      blk <= {blk[503:0], byte_val};
    end
  end

  sha256_sched u_sched (
    .clk     (clk),
    .ctl     (ctl),
    .blk     (blk),
    .sched_w (sched_w)
  );

  sha256_round u_round (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .round_k     (sha256_pkg::round_k(rnd)),
    .sched_w     (sched_w),
    .word_sel    (idx),
    .digest_word (digest_word)
  );

`ifndef SYNTHESIS
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    state == sha256_pkg::S_ROUND && rnd == '1 |=> state == sha256_pkg::S_FOLD)
    else $error("round sequence did not end in fold");

  a_full_block: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && byte_present && fill == '1 |=> state == sha256_pkg::S_LOAD)
    else $error("full block not sent to compression");

  a_out_start: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> word_index == '0 && fill == '0)
    else $error("digest output started misaligned");

  a_end_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_word |=>
      byte_count == '0 && state == sha256_pkg::S_IDLE && !padding)
    else $error("message state not cleared after digest");
`endif

endmodule

// ===== tb/digest_check_pkg.sv =====
package digest_check_pkg;

  import sha256_pkg::HASH_INIT;
  import sha256_pkg::PAD_MARK;
  import sha256_pkg::PAD_LEN_POS;
  import sha256_pkg::count_t;
  import sha256_pkg::len_t;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  class digest_scoreboard;
    logic [31:0]  chain [8];
    logic [7:0]   block_bytes [64];
    count_t       msg_len;
    digest_word_t expected_words [$];
    int           mismatches;
    int           words_checked;
    int           digests_predicted;

    function new();
      mismatches = 0;
      words_checked = 0;
      digests_predicted = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = HASH_INIT[i];
      msg_len = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void fold_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) begin
        w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      end
      for (int t = 16; t < 64; t++) begin
        s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_CONST[t] + w[t];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Advance the hash by one accepted request; an end request queues the digest.
    function void note_request(logic [7:0] data, logic present, logic eom);
      int unsigned pos;
      len_t        bit_len;
      digest_word_t exp_word;
      if (present) begin
        pos = msg_len[5:0];
        block_bytes[pos] = data;
        msg_len = msg_len + 1'b1;
        if (pos == 63) fold_block();
      end
      if (!eom) return;
      pos = msg_len[5:0];
      block_bytes[pos] = PAD_MARK;
      pos++;
      if (pos > PAD_LEN_POS) begin
        while (pos < 64) block_bytes[pos++] = 8'h00;
        fold_block();
        pos = 0;
      end
      while (pos < PAD_LEN_POS) block_bytes[pos++] = 8'h00;
      bit_len = len_t'(msg_len) << 3;
      for (int i = 0; i < 8; i++) block_bytes[PAD_LEN_POS + i] = bit_len[63 - 8*i -: 8];
      fold_block();
      for (int i = 0; i < 8; i++) begin
        exp_word.word = chain[i];
        exp_word.index = 3'(i);
        exp_word.last = (i == 7);
        expected_words = {expected_words, exp_word};
      end
      digests_predicted++;
      restart();
    endfunction

    task flag_mismatch(string what, int n, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH on digest word #%0d: %s got %h want %h", n, what, got, want);
      mismatches++;
    endtask

    task check_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_word_t want;
      if (expected_words.size() == 0) begin
        flag_mismatch("unexpected word", words_checked, word, 32'h0);
      end else begin
        want = expected_words.pop_front();
        if (word !== want.word) flag_mismatch("digest_word", words_checked, word, want.word);
        if (index !== want.index) flag_mismatch("word_index", words_checked, index, want.index);
        if (last !== want.last) flag_mismatch("last_word", words_checked, last, want.last);
      end
      words_checked++;
    endtask
  endclass

endpackage

// ===== tb/tb_sha256_message_digest.sv =====
module tb_sha256_message_digest;

  import digest_check_pkg::*;

  localparam int IDLE_PCT = 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  digest_scoreboard sb = new();
  bit no_gaps = 1'b0;
  int requests_sent = 0;
  int messages_sent = 0;
  int quiet_cycles = 0;

  sha256_message_digest dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .byte_present(byte_present), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_word(digest_word, word_index, last_word);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
          $display("tb_sha256_message_digest NOT OK");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_request(logic [7:0] data, logic present, logic eom);
    while (!no_gaps && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= data;
    byte_present <= present;
    end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(data, present, eom);
    if (present || eom) requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      // drop in an ignored request now and then
      if ($urandom_range(9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
    messages_sent++;
  endtask

  initial begin
    int len;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'ha5, 1'b0, 1'b1);  // empty message, byte ignored
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);  // "abc"
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h5a, 1'b0, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);  // empty again right after a digest
    messages_sent += 5;

    // hold off until every digest word is back
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);

    // a full block whose last byte also ends the message, with no idling at all
    no_gaps = 1'b1;
    send_message(64, 1'b1);
    no_gaps = 1'b0;
    while (requests_sent < 100) begin
      len = $urandom_range(20);
      send_message(len, 1'($urandom_range(1)));
    end
    in_valid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d requests in %0d messages, including empty ones and a full block",
             requests_sent, messages_sent);
    $display("checked %0d digest words from %0d digests, %0d mismatches",
             sb.words_checked, sb.digests_predicted, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("tb_sha256_message_digest OK");
    end else begin
      $display("tb_sha256_message_digest NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sha256_pkg.sv
rtl/sha256_sched.sv
rtl/sha256_round.sv
rtl/sha256_message_digest.sv
tb/digest_check_pkg.sv
tb/tb_sha256_message_digest.sv
